// File: rtl/pba_pkg.sv
// Shared types and constants of the page bitmap allocator.
// Used by the controller, the datapath and the top level.
package pba_pkg;

    localparam int MODE_W     = 3;
    localparam int PAGE_IN_W  = 20;
    localparam int LEN_W      = 14;
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 13;
    localparam int REF_W      = 16;
    localparam int TOTAL_W    = 14;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    localparam logic [REF_W-1:0] REF_LIMIT = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_INIT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_ONE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC_RUN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADD_REF   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_REF  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAILED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_PAGES = 4'd1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET    = 14'd8192;
    localparam logic [TOTAL_W-1:0] RESERVED_RESET = 14'd256;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [PAGE_IN_W-1:0] page_number;
        logic [LEN_W-1:0]     run_length;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_page;
        logic [REF_W-1:0]    ref_count;
        logic [TOTAL_W-1:0]  free_total;
        logic [TOTAL_W-1:0]  used_total;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_INIT_SETUP,
        CMD_SWEEP,
        CMD_SCAN_SETUP,
        CMD_SCAN_READ,
        CMD_SCAN_EVAL,
        CMD_TAKE_READ,
        CMD_TAKE_WRITE,
        CMD_REF_FILL,
        CMD_FETCH,
        CMD_UPDATE,
        CMD_IGNORE,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pre_fail;
        logic              found;
        logic              scan_done;
        logic              word_last;
        logic              ref_last;
        logic              sweep_last;
        logic              out_free;
    } stat_t;

endpackage

// File: rtl/pba_chan_if.sv
// Valid/ready channel carrying one payload word.
// Payload type comes from pba_pkg at instantiation.
interface pba_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pba_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/pba_ctrl.sv
// Sequencer of the page allocator: issues one datapath command per cycle.
// Depends on pba_pkg.
module pba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pba_pkg::stat_t stat,
    output pba_pkg::cmd_t  cmd
);
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SWEEP,
        S_SCAN_RD,
        S_SCAN_EV,
        S_TAKE_RD,
        S_TAKE_WR,
        S_REF_FILL,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = pba_pkg::CMD_NOP;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd = pba_pkg::CMD_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = pba_pkg::CMD_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.mode)
                    pba_pkg::MODE_INIT:
                    begin
                        cmd        = pba_pkg::CMD_INIT_SETUP;
                        state_next = S_SWEEP;
                    end
                    pba_pkg::MODE_ALLOC_ONE, pba_pkg::MODE_ALLOC_RUN:
                    begin
                        cmd        = pba_pkg::CMD_SCAN_SETUP;
                        state_next = stat.pre_fail ? S_FINISH : S_SCAN_RD;
                    end
                    pba_pkg::MODE_FREE, pba_pkg::MODE_ADD_REF, pba_pkg::MODE_READ_REF:
                    begin
                        cmd        = pba_pkg::CMD_FETCH;
                        state_next = S_UPDATE;
                    end
                    default:
                    begin
                        cmd        = pba_pkg::CMD_IGNORE;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SWEEP:
            begin
                cmd = pba_pkg::CMD_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN_RD:
            begin
                cmd        = pba_pkg::CMD_SCAN_READ;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd = pba_pkg::CMD_SCAN_EVAL;
                priority if (stat.found)
                begin
                    state_next = S_TAKE_RD;
                end
                else if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_TAKE_RD:
            begin
                cmd        = pba_pkg::CMD_TAKE_READ;
                state_next = S_TAKE_WR;
            end
            S_TAKE_WR:
            begin
                cmd        = pba_pkg::CMD_TAKE_WRITE;
                state_next = stat.word_last ? S_REF_FILL : S_TAKE_RD;
            end
            S_REF_FILL:
            begin
                cmd = pba_pkg::CMD_REF_FILL;
                if (stat.ref_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_UPDATE:
            begin
                cmd        = pba_pkg::CMD_UPDATE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd        = pba_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            req_ready <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            req_ready <= (state_next == S_IDLE);
        end
    end
endmodule

// File: rtl/pba_datapath.sv
// Datapath of the page allocator: free map and count memories, counters,
// word scan logic and the result register. Depends on pba_pkg and pba_ram.
module pba_datapath #(
    parameter int MAX_PAGES     = 8192,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pba_pkg::cmd_t  cmd,
    output pba_pkg::stat_t stat,
    input  pba_pkg::req_t  req_data,
    input  logic           cfg_we,
    input  pba_pkg::cfg_t  cfg_data,
    input  logic           rsp_ready,
    output logic           rsp_valid,
    output pba_pkg::rsp_t  rsp_data
);
    localparam int W         = MAP_WORD_BITS;
    localparam int BIT_W     = $clog2(W);
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int MAP_WORDS = (MAX_PAGES + W - 1) / W;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int LEN_W     = pba_pkg::LEN_W;
    localparam int REF_W     = pba_pkg::REF_W;
    localparam int CMP_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 2;

    logic [pba_pkg::TOTAL_W-1:0] total_reg;
    logic [pba_pkg::TOTAL_W-1:0] reserved_reg;
    logic [CNT_W-1:0]            map_pages_reg;
    logic [CNT_W-1:0]            res_reg;
    logic [CNT_W-1:0]            free_reg;
    logic [CNT_W-1:0]            used_reg;
    logic [PAGE_W-1:0]           idx_reg;
    logic [WORD_AW-1:0]          widx_reg;
    logic [WORD_AW-1:0]          twidx_reg;
    logic                        rsp_valid_reg;

    logic [pba_pkg::MODE_W-1:0]    mode_reg;
    logic [pba_pkg::PAGE_IN_W-1:0] page_reg;
    logic [LEN_W-1:0]              len_reg;
    logic [CNT_W-1:0]              run_reg;
    logic [PAGE_W-1:0]             first_reg;
    logic [PAGE_W-1:0]             last_reg;
    logic [pba_pkg::STATUS_W-1:0]  rstat_reg;
    logic [pba_pkg::GRANT_W-1:0]   rgrant_reg;
    logic [REF_W-1:0]              rref_reg;
    pba_pkg::rsp_t                 rsp_data_reg;

    logic               ref_we;
    logic [PAGE_W-1:0]  ref_waddr;
    logic [REF_W-1:0]   ref_wdata;
    logic [PAGE_W-1:0]  ref_raddr;
    logic [REF_W-1:0]   ref_rdata;
    logic               map_we;
    logic [WORD_AW-1:0] map_waddr;
    logic [W-1:0]       map_wdata;
    logic [WORD_AW-1:0] map_raddr;
    logic [W-1:0]       map_rdata;

    pba_ram #(.WIDTH(REF_W), .DEPTH(MAX_PAGES)) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    pba_ram #(.WIDTH(W), .DEPTH(MAP_WORDS)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // init geometry
    logic [31:0]      cap_pages;
    logic [CNT_W-1:0] init_pages;
    logic [CNT_W-1:0] init_res;
    logic [CNT_W-1:0] map_words;
    logic [CNT_W-1:0] res_word;
    logic [CNT_W-1:0] sweep_word;
    logic             sweep_in_map;
    logic [W-1:0]     init_word;

    always_comb
    begin
        cap_pages  = (32'(total_reg) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(total_reg);
        init_pages = CNT_W'(cap_pages & ~32'(W - 1));
        init_res   = (CMP_W'(reserved_reg) > CMP_W'(init_pages)) ? init_pages
                                                                  : CNT_W'(reserved_reg);
        map_words    = map_pages_reg >> BIT_W;
        res_word     = res_reg >> BIT_W;
        sweep_word   = CNT_W'(idx_reg);
        sweep_in_map = (32'(idx_reg) < 32'(MAP_WORDS));
        priority if (sweep_word >= map_words || sweep_word < res_word)
        begin
            init_word = '0;
        end
        else if (sweep_word == res_word)
        begin
            init_word = {W{1'b1}} << res_reg[BIT_W-1:0];
        end
        else
        begin
            init_word = {W{1'b1}};
        end
    end

    // word scan: highest window of len_reg free pages, with run carried from above
    logic [BIT_W:0]   lead1;
    logic [BIT_W:0]   trail1;
    logic [W-1:0]     win [BIT_W+1];
    logic [W-1:0]     win_hit;
    logic [BIT_W+1:0] win_sh;
    logic [BIT_W-1:0] pos_int;
    logic [BIT_W-1:0] pos_carry;
    logic [BIT_W-1:0] pos;
    logic             found_carry;
    logic             found_int;
    logic             scan_found;
    logic [CNT_W-1:0] run_next;
    logic [PAGE_W-1:0] found_first;
    logic [PAGE_W-1:0] found_last;

    always_comb
    begin
        lead1 = (BIT_W+1)'(W);
        for (int b = 0; b < W; b++)
        begin
            if (!map_rdata[b])
            begin
                lead1 = (BIT_W+1)'(W - 1 - b);
            end
        end
        trail1 = (BIT_W+1)'(W);
        for (int b = W - 1; b >= 0; b--)
        begin
            if (!map_rdata[b])
            begin
                trail1 = (BIT_W+1)'(b);
            end
        end
        win[0] = map_rdata;
        for (int i = 1; i <= BIT_W; i++)
        begin
            win[i] = win[i-1] & (win[i-1] >> (1 << (i - 1)));
        end
        win_hit = {W{1'b1}};
        win_sh  = '0;
        for (int i = 0; i <= BIT_W; i++)
        begin
            if (len_reg[i])
            begin
                win_hit = win_hit & (win[i] >> win_sh);
                win_sh  = win_sh + (BIT_W+2)'(1 << i);
            end
        end
        pos_int = '0;
        for (int b = 0; b < W; b++)
        begin
            if (win_hit[b])
            begin
                pos_int = BIT_W'(b);
            end
        end
        found_carry = (CMP_W'(run_reg) + CMP_W'(lead1)) >= CMP_W'(len_reg);
        pos_carry   = BIT_W'(CMP_W'(run_reg) + CMP_W'(W) - CMP_W'(len_reg));
        found_int   = (CMP_W'(len_reg) <= CMP_W'(W)) && (|win_hit);
        scan_found  = found_carry || found_int;
        pos         = found_carry ? pos_carry : pos_int;
        run_next    = (&map_rdata) ? CNT_W'(CMP_W'(run_reg) + CMP_W'(W)) : CNT_W'(trail1);
        found_first = PAGE_W'({widx_reg, pos});
        found_last  = PAGE_W'(CMP_W'(found_first) + CMP_W'(len_reg) - CMP_W'(1));
    end

    // page range clear of one map word
    logic [WORD_AW-1:0] first_word;
    logic [WORD_AW-1:0] last_word;
    logic [BIT_W-1:0]   take_lo;
    logic [BIT_W-1:0]   take_hi;
    logic [W-1:0]       take_mask;

    always_comb
    begin
        first_word = WORD_AW'(first_reg >> BIT_W);
        last_word  = WORD_AW'(last_reg >> BIT_W);
        take_lo    = (twidx_reg == first_word) ? first_reg[BIT_W-1:0] : '0;
        take_hi    = (twidx_reg == last_word) ? last_reg[BIT_W-1:0] : BIT_W'(W - 1);
        take_mask  = ({W{1'b1}} << take_lo) & ({W{1'b1}} >> (BIT_W'(W - 1) - take_hi));
    end

    // free, add_reference, read_refcount
    logic [PAGE_W-1:0]            page_idx;
    logic [WORD_AW-1:0]           page_word;
    logic [BIT_W-1:0]             page_bit;
    logic                         page_in_map;
    logic                         page_tracked;
    logic [pba_pkg::STATUS_W-1:0] upd_status;
    logic [REF_W-1:0]             upd_refc;
    logic                         upd_ref_we;
    logic [REF_W-1:0]             upd_ref_val;
    logic                         upd_release;

    always_comb
    begin
        page_idx     = PAGE_W'(page_reg);
        page_word    = WORD_AW'(page_idx >> BIT_W);
        page_bit     = page_idx[BIT_W-1:0];
        page_in_map  = 32'(page_reg) < 32'(map_pages_reg);
        page_tracked = 32'(page_reg) < 32'(MAX_PAGES);
        upd_status   = pba_pkg::ST_DONE;
        upd_refc     = page_tracked ? ref_rdata : REF_W'(1);
        upd_ref_we   = 1'b0;
        upd_ref_val  = ref_rdata;
        upd_release  = 1'b0;
        if (mode_reg == pba_pkg::MODE_FREE)
        begin
            priority if (!page_in_map || ref_rdata == '0)
            begin
                upd_status = pba_pkg::ST_IGNORED;
            end
            else if (ref_rdata > REF_W'(1))
            begin
                upd_ref_we  = 1'b1;
                upd_ref_val = ref_rdata - REF_W'(1);
                upd_refc    = ref_rdata - REF_W'(1);
            end
            else
            begin
                upd_ref_we  = 1'b1;
                upd_ref_val = '0;
                upd_refc    = '0;
                upd_release = !map_rdata[page_bit];
            end
        end
        else if (mode_reg == pba_pkg::MODE_ADD_REF)
        begin
            if (!page_tracked)
            begin
                upd_status = pba_pkg::ST_IGNORED;
            end
            else
            begin
                upd_ref_we  = 1'b1;
                upd_ref_val = (ref_rdata != pba_pkg::REF_LIMIT) ? ref_rdata + REF_W'(1)
                                                                : ref_rdata;
                upd_refc    = upd_ref_val;
            end
        end
    end

    // memory ports
    always_comb
    begin
        ref_we    = 1'b0;
        ref_waddr = idx_reg;
        ref_wdata = '0;
        ref_raddr = page_idx;
        map_we    = 1'b0;
        map_waddr = WORD_AW'(idx_reg);
        map_wdata = init_word;
        map_raddr = widx_reg;
        unique case (cmd)
            pba_pkg::CMD_SWEEP:
            begin
                ref_we = 1'b1;
                map_we = sweep_in_map;
            end
            pba_pkg::CMD_REF_FILL:
            begin
                ref_we    = 1'b1;
                ref_wdata = REF_W'(1);
            end
            pba_pkg::CMD_TAKE_READ:
            begin
                map_raddr = twidx_reg;
            end
            pba_pkg::CMD_TAKE_WRITE:
            begin
                map_we    = 1'b1;
                map_waddr = twidx_reg;
                map_wdata = map_rdata & ~take_mask;
            end
            pba_pkg::CMD_FETCH:
            begin
                map_raddr = page_word;
            end
            pba_pkg::CMD_UPDATE:
            begin
                ref_we    = upd_ref_we;
                ref_waddr = page_idx;
                ref_wdata = upd_ref_val;
                map_we    = upd_release;
                map_waddr = page_word;
                map_wdata = map_rdata | (W'(1) << page_bit);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= pba_pkg::TOTAL_RESET;
            reserved_reg  <= pba_pkg::RESERVED_RESET;
            map_pages_reg <= '0;
            res_reg       <= '0;
            free_reg      <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            widx_reg      <= '0;
            twidx_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                priority if (cfg_data.index == pba_pkg::REG_TOTAL_PAGES)
                begin
                    total_reg <= pba_pkg::TOTAL_W'(cfg_data.value);
                end
                else if (cfg_data.index == pba_pkg::REG_RESERVED_PAGES)
                begin
                    reserved_reg <= pba_pkg::TOTAL_W'(cfg_data.value);
                end
            end
            unique case (cmd)
                pba_pkg::CMD_INIT_SETUP:
                begin
                    map_pages_reg <= init_pages;
                    res_reg       <= init_res;
                    free_reg      <= init_pages - init_res;
                    used_reg      <= '0;
                    idx_reg       <= '0;
                end
                pba_pkg::CMD_SWEEP, pba_pkg::CMD_REF_FILL:
                begin
                    idx_reg <= idx_reg + PAGE_W'(1);
                end
                pba_pkg::CMD_SCAN_SETUP:
                begin
                    widx_reg <= WORD_AW'(map_words - CNT_W'(1));
                end
                pba_pkg::CMD_SCAN_EVAL:
                begin
                    if (scan_found)
                    begin
                        twidx_reg <= widx_reg;
                        idx_reg   <= found_first;
                        used_reg  <= CNT_W'(CMP_W'(used_reg) + CMP_W'(len_reg));
                        free_reg  <= (CMP_W'(free_reg) > CMP_W'(len_reg))
                                     ? CNT_W'(CMP_W'(free_reg) - CMP_W'(len_reg)) : '0;
                    end
                    else
                    begin
                        widx_reg <= widx_reg - WORD_AW'(1);
                    end
                end
                pba_pkg::CMD_TAKE_WRITE:
                begin
                    twidx_reg <= twidx_reg + WORD_AW'(1);
                end
                pba_pkg::CMD_UPDATE:
                begin
                    if (upd_release)
                    begin
                        used_reg <= (used_reg != '0) ? used_reg - CNT_W'(1) : '0;
                        free_reg <= free_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd == pba_pkg::CMD_EMIT)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            pba_pkg::CMD_LATCH:
            begin
                mode_reg <= req_data.mode;
                page_reg <= req_data.page_number;
                len_reg  <= (req_data.mode == pba_pkg::MODE_ALLOC_RUN
                             && req_data.run_length != '0) ? req_data.run_length
                                                           : LEN_W'(1);
            end
            pba_pkg::CMD_INIT_SETUP:
            begin
                rstat_reg  <= pba_pkg::ST_DONE;
                rgrant_reg <= '0;
                rref_reg   <= '0;
            end
            pba_pkg::CMD_SCAN_SETUP:
            begin
                run_reg    <= '0;
                rstat_reg  <= pba_pkg::ST_FAILED;
                rgrant_reg <= '0;
                rref_reg   <= '0;
            end
            pba_pkg::CMD_SCAN_EVAL:
            begin
                if (scan_found)
                begin
                    first_reg  <= found_first;
                    last_reg   <= found_last;
                    rstat_reg  <= pba_pkg::ST_DONE;
                    rgrant_reg <= pba_pkg::GRANT_W'(found_first);
                    rref_reg   <= REF_W'(1);
                end
                else
                begin
                    run_reg <= run_next;
                end
            end
            pba_pkg::CMD_UPDATE:
            begin
                rstat_reg  <= upd_status;
                rgrant_reg <= '0;
                rref_reg   <= upd_refc;
            end
            pba_pkg::CMD_IGNORE:
            begin
                rstat_reg  <= pba_pkg::ST_IGNORED;
                rgrant_reg <= '0;
                rref_reg   <= '0;
            end
            pba_pkg::CMD_EMIT:
            begin
                rsp_data_reg.status       <= rstat_reg;
                rsp_data_reg.granted_page <= rgrant_reg;
                rsp_data_reg.ref_count    <= rref_reg;
                rsp_data_reg.free_total   <= pba_pkg::TOTAL_W'(free_reg);
                rsp_data_reg.used_total   <= pba_pkg::TOTAL_W'(used_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.pre_fail   = (map_words == '0)
                          || (mode_reg == pba_pkg::MODE_ALLOC_RUN
                              && (CMP_W'(len_reg) > CMP_W'(free_reg)
                                  || CMP_W'(len_reg) > CMP_W'(map_pages_reg)));
        stat.found      = scan_found;
        stat.scan_done  = (widx_reg == '0);
        stat.word_last  = (twidx_reg == last_word);
        stat.ref_last   = (idx_reg == last_reg);
        stat.sweep_last = (idx_reg == PAGE_W'(MAX_PAGES - 1));
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

    a_free_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= map_pages_reg)
        else $error("free counter exceeds managed pages");

    a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W'(free_reg) + CMP_W'(used_reg)) <= CMP_W'(map_pages_reg))
        else $error("free plus used counters exceed managed pages");

    a_grant_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == pba_pkg::CMD_SCAN_EVAL && scan_found)
        |=> (CMP_W'(last_reg) < CMP_W'(map_pages_reg)))
        else $error("granted run extends past managed pages");
endmodule

// File: rtl/page_bitmap_allocator_refcount.sv
// Top level of the page bitmap allocator with per-page reference counts.
// Depends on pba_pkg, pba_chan_if, pba_ctrl, pba_datapath and pba_ram.
//
// One request word gives one response word. After reset, and for every init
// request, a clearing pass writes every count entry and map word, one entry a
// cycle, during which no request is taken; configuration writes are taken at
// all times but belong to idle periods. An allocation scans the free map from
// the top word down, reading and then evaluating each word, then reads and
// writes back each map word it touches and writes a count entry per page
// granted; free, add_reference and read_refcount fetch the count entry and map
// word, then write back as the mode requires. The next request is taken while a response waits.
// MAP_WORD_BITS must be a power of two and divide MAX_PAGES.
module page_bitmap_allocator_refcount #(
    parameter int MAX_PAGES     = 8192,
    parameter int MAP_WORD_BITS = 32
) (
    input logic       clk,
    input logic       rst_n,
    pba_chan_if.sink   req,
    pba_chan_if.source rsp,
    pba_chan_if.sink   cfg
);
    pba_pkg::cmd_t  cmd;
    pba_pkg::stat_t stat;
    logic           req_ready;

    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pba_datapath #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_data  (req.data),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data)
    );

    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;
endmodule

// File: test/tb_pba_if.sv
`timescale 1ns / 100ps
// Testbench-side note: channels use pba_chan_if from the RTL; this file holds
// the testbench page count and map word width. Depends on pba_pkg.
package tb_pba_pkg;
    import pba_pkg::*;
    localparam int TB_MAX_PAGES = 8192;
    localparam int TB_WORD_BITS = 32;
endpackage

// File: test/tb_pba_checker.sv
`timescale 1ns / 100ps
// Allocator checker: mirrors the free map, counts and counters, predicts each
// response word and compares it field by field. Depends on pba_pkg, tb_pba_pkg.
module tb_pba_checker
    import pba_pkg::*;
    import tb_pba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_data,
    input  logic cfg_valid,
    input  logic cfg_ready,
    input  cfg_t cfg_data,
    output int   fail_count,
    output int   pending
);
    logic [TB_MAX_PAGES-1:0] page_free;
    logic [REF_W-1:0]        page_ref [TB_MAX_PAGES];
    int unsigned             total_reg, reserved_reg, map_size, free_cnt, used_cnt;
    rsp_t                    expected_q [$];

    function automatic int unsigned ref_of(int unsigned p);
        return (p < TB_MAX_PAGES) ? page_ref[p] : 1;
    endfunction

    function automatic void grab(int unsigned first, int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            page_free[first+i] = 1'b0;
            page_ref[first+i]  = 1;
        end
        used_cnt += n;
        free_cnt = (free_cnt > n) ? free_cnt - n : 0;
    endfunction

    function automatic rsp_t serve(req_t r);
        rsp_t        o;
        int unsigned pg, len, run, res;
        o = '0;
        pg = r.page_number;
        len = r.run_length;
        case (r.mode)
            MODE_INIT:
            begin
                map_size = (total_reg > TB_MAX_PAGES) ? TB_MAX_PAGES : total_reg;
                map_size -= map_size % TB_WORD_BITS;
                res = (reserved_reg > map_size) ? map_size : reserved_reg;
                page_free = '0;
                for (int i = 0; i < TB_MAX_PAGES; i++)
                    page_ref[i] = '0;
                for (int unsigned p = res; p < map_size; p++)
                    page_free[p] = 1'b1;
                free_cnt = map_size - res;
                used_cnt = 0;
            end
            MODE_ALLOC_ONE:
            begin
                o.status = ST_FAILED;
                for (int unsigned p = map_size; p > 0; p--)
                    if (page_free[p-1])
                    begin
                        grab(p - 1, 1);
                        o.granted_page = p - 1;
                        o.ref_count = 1;
                        o.status = ST_DONE;
                        break;
                    end
            end
            MODE_ALLOC_RUN:
            begin
                if (len == 0)
                    len = 1;
                o.status = ST_FAILED;
                if (len <= free_cnt && len <= map_size)
                begin
                    run = 0;
                    for (int unsigned p = map_size; p > 0; p--)
                    begin
                        run = page_free[p-1] ? run + 1 : 0;
                        if (run >= len)
                        begin
                            grab(p - 1, len);
                            o.granted_page = p - 1;
                            o.ref_count = 1;
                            o.status = ST_DONE;
                            break;
                        end
                    end
                end
            end
            MODE_FREE:
            begin
                if (pg >= map_size || page_ref[pg] == 0)
                    o.status = ST_IGNORED;
                else if (page_ref[pg] > 1)
                    page_ref[pg]--;
                else
                begin
                    page_ref[pg] = 0;
                    if (!page_free[pg])
                    begin
                        page_free[pg] = 1'b1;
                        if (used_cnt > 0)
                            used_cnt--;
                        free_cnt++;
                    end
                end
                o.ref_count = ref_of(pg);
            end
            MODE_ADD_REF:
            begin
                if (pg >= TB_MAX_PAGES)
                    o.status = ST_IGNORED;
                else if (page_ref[pg] < REF_LIMIT)
                    page_ref[pg]++;
                o.ref_count = ref_of(pg);
            end
            MODE_READ_REF:
                o.ref_count = ref_of(pg);
            default:
                o.status = ST_IGNORED;
        endcase
        o.free_total = free_cnt;
        o.used_total = used_cnt;
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            total_reg = TOTAL_RESET;
            reserved_reg = RESERVED_RESET;
            map_size = 0;
            free_cnt = 0;
            used_cnt = 0;
            page_free = '0;
            for (int i = 0; i < TB_MAX_PAGES; i++)
                page_ref[i] = '0;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data.index == REG_TOTAL_PAGES)
                    total_reg = cfg_data.value;
                else if (cfg_data.index == REG_RESERVED_PAGES)
                    reserved_reg = cfg_data.value;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, rsp_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.status !== rsp_data.status)
                        $display("%0t: status exp %0d got %0d", $time, want.status,
                                 rsp_data.status);
                    if (want.granted_page !== rsp_data.granted_page)
                        $display("%0t: granted_page exp %0d got %0d", $time,
                                 want.granted_page, rsp_data.granted_page);
                    if (want.ref_count !== rsp_data.ref_count)
                        $display("%0t: ref_count exp %0d got %0d", $time,
                                 want.ref_count, rsp_data.ref_count);
                    if (want.free_total !== rsp_data.free_total)
                        $display("%0t: free_total exp %0d got %0d", $time,
                                 want.free_total, rsp_data.free_total);
                    if (want.used_total !== rsp_data.used_total)
                        $display("%0t: used_total exp %0d got %0d", $time,
                                 want.used_total, rsp_data.used_total);
                    if (want !== rsp_data)
                        fail_count++;
                end
            end
            if (req_valid && req_ready)
                expected_q.push_back(serve(req_data));
        end
    end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and configuration
// stimulus, response stalls, verdict. Depends on pba_pkg and tb_pba_checker.
module tb_top;
    import pba_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   calm;

    pba_chan_if #(.payload_t(req_t)) req_ch ();
    pba_chan_if #(.payload_t(rsp_t)) rsp_ch ();
    pba_chan_if #(.payload_t(cfg_t)) cfg_ch ();

    page_bitmap_allocator_refcount u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    tb_pba_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_ch.valid),
        .req_ready  (req_ch.ready),
        .req_data   (req_ch.data),
        .rsp_valid  (rsp_ch.valid),
        .rsp_ready  (rsp_ch.ready),
        .rsp_data   (rsp_ch.data),
        .cfg_valid  (cfg_ch.valid),
        .cfg_ready  (cfg_ch.ready),
        .cfg_data   (cfg_ch.data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= calm || ($urandom_range(99) >= 22);
    end

    task automatic send(logic [2:0] m, logic [19:0] pg, logic [13:0] len);
        if (!calm)
            while ($urandom_range(99) < 22)
                @(posedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= '{mode: m, page_number: pg, run_length: len};
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [13:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic phase(logic [13:0] tot, logic [13:0] rsv, int n);
        int          r;
        logic [19:0] pg;
        drain();
        write_reg(REG_TOTAL_PAGES, tot);
        write_reg(REG_RESERVED_PAGES, rsv);
        send(MODE_INIT, $urandom, $urandom);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            pg = (r % 4 == 0) ? $urandom : $urandom_range(tot + 40);
            if (r < 25)
                send(MODE_ALLOC_ONE, $urandom, $urandom);
            else if (r < 40)
                send(MODE_ALLOC_RUN, $urandom, (r < 30) ? $urandom : $urandom_range(40));
            else if (r < 65)
                send(MODE_FREE, pg, $urandom);
            else if (r < 80)
                send(MODE_ADD_REF, pg, $urandom);
            else if (r < 94)
                send(MODE_READ_REF, pg, $urandom);
            else if (r < 97)
                send($urandom_range(7, 6), pg, $urandom);
            else
                send(MODE_INIT, pg, $urandom);
        end
    endtask

    initial
    begin
        #100000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(MODE_ALLOC_ONE, 0, 0);
        send(MODE_ALLOC_RUN, 0, 0);
        send(MODE_FREE, 0, 0);
        send(MODE_READ_REF, 20'hFFFFF, 0);
        send(MODE_ADD_REF, 20'hFFFFF, 0);
        drain();
        write_reg(REG_TOTAL_PAGES, 14'h3FFF);
        write_reg(REG_RESERVED_PAGES, 14'h3FFF);
        send(MODE_INIT, 0, 0);
        send(MODE_ALLOC_ONE, 0, 0);
        send(MODE_ALLOC_RUN, 0, 14'h3FFF);
        drain();
        write_reg(REG_TOTAL_PAGES, 14'd70);
        write_reg(REG_RESERVED_PAGES, 14'd3);
        send(MODE_INIT, 0, 0);
        send(MODE_ALLOC_RUN, 0, 14'd61);
        send(MODE_ALLOC_RUN, 0, 14'd0);
        send(MODE_ALLOC_RUN, 0, 14'd2);
        send(MODE_FREE, 20'd63, 0);
        send(MODE_FREE, 20'd63, 0);
        send(MODE_FREE, 20'd64, 0);
        send(MODE_ADD_REF, 20'd2, 0);
        send(MODE_READ_REF, 20'd2, 0);
        send(MODE_FREE, 20'd2, 0);
        send(MODE_FREE, 20'd2, 0);
        send(3'd6, 20'hAAAAA, 14'h2AAA);
        send(3'd7, 20'h55555, 14'h1555);
        for (int i = 0; i < 20; i++)
            send(MODE_ADD_REF, 20'd10, 0);
        drain();
        write_reg(REG_TOTAL_PAGES, 14'd32);
        write_reg(REG_RESERVED_PAGES, 14'd0);
        send(MODE_INIT, 0, 0);
        for (int i = 0; i < 3; i++)
            send(MODE_ADD_REF, 20'd5, 0);
        send(MODE_FREE, 20'd5, 0);
        calm = 1'b1;
        phase(14'd64, 14'd0, 300);
        calm = 1'b0;
        phase(14'd96, 14'd10, 350);
        phase(14'd8192, 14'd256, 60);
        phase(14'd50, 14'd100, 300);
        phase(14'd128, 14'd31, 300);
        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
